### design/gdw_pkg.sv
// Shared types and constants for the grid DDA wall column caster.
// No dependencies.
package gdw_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAYX,
        ST_RAYY,
        ST_CAMX,
        ST_DIVY,
        ST_SIDEX,
        ST_SIDEY,
        ST_WALK,
        ST_DIST,
        ST_DIVH,
        ST_SPAN,
        ST_OUT
    } t_state;

    localparam logic [2:0] REG_CAM_X   = 3'd0;
    localparam logic [2:0] REG_CAM_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_WALLS   = 3'd6;

    localparam int DIST_W = 36;

    // Control between sequencer and divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

### design/grid_dda_wall_column_top.sv
// Grid DDA ray caster for one screen column per transfer.
// One column is in flight at a time: after the input transfer the sequencer
// runs up to three passes of the shared divider (delta x, delta y, wall
// height, skipped when the wall distance is zero) and a walk of 1..18 DDA
// steps, then holds the result until the output transfer.
// Synchronous active-low reset restores the default camera and room map.
module grid_dda_wall_column_top
    import gdw_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 320,
    parameter int SCREEN_ROWS    = 200,
    parameter int GRID_SIDE      = 8,
    parameter int FRAC_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [8:0]  i_column,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [8:0]  o_column_echo,
    output logic [7:0]  o_span_top,
    output logic [7:0]  o_span_bottom,
    output logic        o_hit_side,
    output logic [2:0]  o_hit_cell_x,
    output logic [2:0]  o_hit_cell_y
);
    localparam int F  = FRAC_BITS;
    localparam int DW = 2 * F + 16;       // divider width
    localparam int RW = 2 + F + 24;       // ray width, wide enough for product
    localparam int MW = 8;                // map coordinate, signed
    localparam int SW = DIST_W + 6;       // side distance, room for 18 steps
    localparam int CX_W = F + 11;         // camera coordinate, signed
    localparam int PW = 18 + CX_W;        // plane * camx product
    localparam logic [DIST_W-1:0] DSAT = {DIST_W{1'b1}};
    localparam logic [DW-1:0] ROWS_Q = DW'(SCREEN_ROWS) << F;
    localparam int HALF = SCREEN_ROWS / 2;
    localparam int MAXN = 2 * GRID_SIDE + 2;
    // camx quotient by reciprocal multiplication, exact for a 9-bit column
    localparam int CN_W = F + 10;
    localparam int CLOG_C = $clog2(SCREEN_COLUMNS);
    localparam int RK = CN_W + CLOG_C;
    localparam longint unsigned RECIP = ((64'd1 << RK) + 64'(SCREEN_COLUMNS) - 64'd1)
                                        / 64'(SCREEN_COLUMNS);
    localparam int RECIP_W = CN_W + 2;
    localparam int CP_W = RECIP_W + 9;

    // configuration
    logic [18:0] r_cam_x, r_cam_y;
    logic signed [17:0] r_dir_x, r_dir_y, r_pl_x, r_pl_y;
    logic [63:0] r_walls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= 19'd131072;
            r_cam_y <= 19'd131072;
            r_dir_x <= -18'sd65536;
            r_dir_y <= 18'sd0;
            r_pl_x  <= 18'sd0;
            r_pl_y  <= 18'sd43254;
            r_walls <= 64'd133430317343;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CAM_X:   r_cam_x <= i_cfg_data[18:0];
                REG_CAM_Y:   r_cam_y <= i_cfg_data[18:0];
                REG_DIR_X:   r_dir_x <= i_cfg_data[17:0];
                REG_DIR_Y:   r_dir_y <= i_cfg_data[17:0];
                REG_PLANE_X: r_pl_x  <= i_cfg_data[17:0];
                REG_PLANE_Y: r_pl_y  <= i_cfg_data[17:0];
                REG_WALLS:   r_walls <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic [8:0] r_col;
    logic signed [CX_W-1:0] r_camx;
    logic signed [RW-1:0] r_rx, r_ry;
    logic [DIST_W-1:0] r_dx, r_dy;
    logic [SW-1:0] r_sdx, r_sdy;
    logic signed [MW-1:0] r_mx, r_my;
    logic r_side, r_hit;
    logic [4:0] r_n;
    logic [DW-1:0] r_height;
    logic [7:0] r_top, r_bot;

    // divider
    logic w_dstart;
    logic [DW-1:0] w_dnum, w_dden, w_quot;
    t_div_ctl w_dctl;

    gdw_divider #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_ctl(w_dctl), .o_quot(w_quot)
    );

    // camera coordinate: floor((2*column << F) / SCREEN_COLUMNS) - 1.0
    logic [CP_W-1:0] w_cprod;
    logic signed [CX_W-1:0] w_camx;
    assign w_cprod = CP_W'(r_col) * CP_W'(RECIP);
    assign w_camx = CX_W'(w_cprod >> (RK - F - 1)) - (CX_W'(1) << F);

    // shared multiplier: plane * camx
    logic signed [17:0] w_pl;
    logic signed [PW-1:0] w_prod;
    logic signed [RW-1:0] w_ray;
    logic signed [17:0] w_dir;
    assign w_pl  = (r_state == ST_RAYX) ? r_pl_x : r_pl_y;
    assign w_dir = (r_state == ST_RAYX) ? r_dir_x : r_dir_y;
    assign w_prod = PW'(w_pl) * PW'(r_camx);
    // arithmetic shift floors
    assign w_ray = RW'(w_dir) + RW'(w_prod >>> F);

    logic [RW-1:0] w_mag;
    logic signed [RW-1:0] w_cur_ray;
    assign w_cur_ray = (r_state == ST_RAYY) ? r_rx : r_ry;
    assign w_mag = w_cur_ray[RW-1] ? RW'(-w_cur_ray) : RW'(w_cur_ray);

    // side init multiplier
    logic [F:0] w_frac;
    logic [18:0] w_pos;
    logic w_rneg;
    logic [DIST_W-1:0] w_del;
    logic [DIST_W+F:0] w_sprod;
    assign w_pos  = (r_state == ST_SIDEX) ? r_cam_x : r_cam_y;
    assign w_rneg = (r_state == ST_SIDEX) ? r_rx[RW-1] : r_ry[RW-1];
    assign w_del  = (r_state == ST_SIDEX) ? r_dx : r_dy;
    assign w_frac = w_rneg ? (F+1)'(w_pos[F-1:0]) : ((F+1)'(1) << F) - (F+1)'(w_pos[F-1:0]);
    assign w_sprod = (DIST_W+F+1)'(w_frac) * (DIST_W+F+1)'(w_del);

    // DDA step
    logic w_stepx;
    logic signed [MW-1:0] w_nmx, w_nmy;
    logic w_out, w_wall, w_hitn;
    logic [5:0] w_bidx;
    assign w_stepx = r_sdx < r_sdy;
    assign w_nmx = w_stepx ? (r_rx[RW-1] ? r_mx - 1'b1 : r_mx + 1'b1) : r_mx;
    assign w_nmy = w_stepx ? r_my : (r_ry[RW-1] ? r_my - 1'b1 : r_my + 1'b1);
    assign w_out = w_nmx < 0 || w_nmy < 0 || w_nmx >= MW'(GRID_SIDE)
                   || w_nmy >= MW'(GRID_SIDE);
    assign w_bidx = {w_nmy[2:0], w_nmx[2:0]};
    assign w_wall = r_walls[w_bidx];
    assign w_hitn = w_out || w_wall;

    logic [SW-1:0] w_dist;
    assign w_dist = r_side ? r_sdy - SW'(r_dy) : r_sdx - SW'(r_dx);

    logic r_dy_phase;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_CAMX;
            ST_CAMX:  n_state = ST_RAYX;
            ST_RAYX:  n_state = ST_RAYY;
            ST_RAYY:  n_state = ST_DIVY;
            ST_DIVY:  if (w_dctl.done && r_dy_phase) n_state = ST_SIDEX;
            ST_SIDEX: n_state = ST_SIDEY;
            ST_SIDEY: n_state = ST_WALK;
            ST_WALK:  if (r_hit || r_n == 5'(MAXN)) n_state = ST_DIST;
            ST_DIST:  n_state = (w_dist != '0) ? ST_DIVH : ST_OUT;
            ST_DIVH:  if (w_dctl.done) n_state = ST_SPAN;
            ST_SPAN:  n_state = ST_OUT;
            ST_OUT:   if (!i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // divider request and operands
    always_comb begin
        w_dstart = 1'b0;
        w_dnum = '0;
        w_dden = DW'(1);
        case (r_state)
            ST_RAYY: begin
                // delta x
                w_dstart = 1'b1;
                w_dnum = DW'(1) << (2 * F);
                w_dden = DW'(w_mag == '0 ? RW'(1) : w_mag);
            end
            ST_DIVY: begin
                // delta y right after delta x
                w_dstart = w_dctl.done && !r_dy_phase;
                w_dnum = DW'(1) << (2 * F);
                w_dden = DW'(w_mag == '0 ? RW'(1) : w_mag);
            end
            ST_DIST: begin
                w_dstart = (w_dist != '0);
                w_dnum = ROWS_Q;
                w_dden = DW'(w_dist);
            end
            default: ;
        endcase
    end

    logic [DW-1:0] w_dsat;
    assign w_dsat = (w_quot > DW'(DSAT)) ? DW'(DSAT) : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dy_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RAYY) r_dy_phase <= 1'b0;
            if (r_state == ST_DIVY && w_dctl.done) r_dy_phase <= ~r_dy_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (i_valid) r_col <= i_column;
            ST_CAMX: r_camx <= w_camx;
            ST_RAYX: r_rx <= w_ray;
            ST_RAYY: r_ry <= w_ray;
            ST_SIDEX: r_sdx <= SW'(w_sprod >> F);
            ST_SIDEY: begin
                r_sdy  <= SW'(w_sprod >> F);
                r_mx   <= MW'(r_cam_x[18:F]);
                r_my   <= MW'(r_cam_y[18:F]);
                r_n    <= '0;
                r_hit  <= 1'b0;
                r_side <= 1'b0;
            end
            ST_WALK: if (!r_hit && r_n != 5'(MAXN)) begin
                r_n <= r_n + 1'b1;
                r_mx <= w_nmx;
                r_my <= w_nmy;
                r_hit <= w_hitn;
                r_side <= !w_stepx;
                if (w_stepx) r_sdx <= r_sdx + SW'(r_dx);
                else         r_sdy <= r_sdy + SW'(r_dy);
            end
            ST_DIST: if (w_dist == '0) begin
                r_top <= 8'd0;
                r_bot <= 8'(SCREEN_ROWS - 1);
            end
            ST_DIVH: if (w_dctl.done) r_height <= w_quot;
            ST_SPAN: begin
                r_top <= (r_height[DW-1:1] >= DW'(HALF)) ? 8'd0
                         : 8'(DW'(HALF) - (r_height >> 1));
                r_bot <= ((r_height >> 1) + DW'(HALF) >= DW'(SCREEN_ROWS))
                         ? 8'(SCREEN_ROWS - 1) : 8'((r_height >> 1) + DW'(HALF));
            end
            default: ;
        endcase
        // deltas from the shared division
        if (r_state == ST_DIVY && w_dctl.done) begin
            if (!r_dy_phase) r_dx <= (r_rx == '0) ? DSAT : DIST_W'(w_dsat);
            else             r_dy <= (r_ry == '0) ? DSAT : DIST_W'(w_dsat);
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_column_echo = r_col;
    assign o_span_top = r_top;
    assign o_span_bottom = r_bot;
    assign o_hit_side = r_side;
    assign o_hit_cell_x = r_mx < 0 ? 3'd0 : (r_mx > MW'(GRID_SIDE - 1)
                          ? 3'(GRID_SIDE - 1) : r_mx[2:0]);
    assign o_hit_cell_y = r_my < 0 ? 3'd0 : (r_my > MW'(GRID_SIDE - 1)
                          ? 3'(GRID_SIDE - 1) : r_my[2:0]);

`ifndef ASSERT_OFF
    a_out_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("output while accepting");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> r_n <= 5'(MAXN)) else $error("walk overrun");
`endif

endmodule

### design/gdw_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses gdw_pkg for the control struct.
module gdw_divider
    import gdw_pkg::*;
#(
    parameter int W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output t_div_ctl     o_ctl,
    output logic [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  r_q;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_den;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem[W-1:0], r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            // shift in next dividend bit, subtract where it fits
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quot = r_q;

`ifndef ASSERT_OFF
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider did not start");
`endif

endmodule
